// File: hw/rtl/mpe_pkg.sv
// Shared types, codes and constants of the multivariate polynomial evaluator.
package mpe_pkg;

	localparam int CHANNELS_DEF  = 16;
	localparam int MAX_VARS_DEF  = 8;
	localparam int MAX_TERMS_DEF = 64;

	localparam logic [1:0] CMD_HEADER = 2'd0;
	localparam logic [1:0] CMD_RANGE  = 2'd1;
	localparam logic [1:0] CMD_TERM   = 2'd2;
	localparam logic [1:0] CMD_SAMPLE = 2'd3;

	localparam logic [31:0] ONE_Q28 = 32'h1000_0000;

	typedef enum logic [1:0] {
		MS_V,
		MS_POW,
		MS_TERM
	} mul_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_VRD,
		S_VMUL,
		S_VWAIT,
		S_TRD,
		S_TLOAD,
		S_FAC,
		S_POW,
		S_PWAIT,
		S_TWAIT,
		S_ACC,
		S_DONE
	} state_t;

	typedef struct packed {
		logic     acc_init;
		logic     rng_rd;
		logic     coef_rd;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     term_load;
		logic     term_zero;
		logic     r_load;
		logic     acc_add;
		logic     out_load;
	} ctl_t;

	typedef struct packed {
		logic       eval_req;
		logic       var_end;
		logic       term_end;
		logic       mul_done;
		logic [3:0] pnib;
	} sts_t;

endpackage

// File: hw/rtl/mpe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: hw/rtl/mpe_mul.sv
// Shared multiply, shift and saturate unit built on one 32x32 multiplier.
module mpe_mul (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  mpe_pkg::mul_sel_t sel,
	input  logic [63:0]      ua,
	input  logic [31:0]      ub,
	input  logic             neg,
	output logic             done,
	output logic [63:0]      res,
	output logic             sat
);
	import mpe_pkg::*;

	logic [1:0]  phase_q;
	logic [63:0] ua_q;
	logic [31:0] ub_q;
	logic        neg_q;
	mul_sel_t    sel_q;
	logic [95:0] prod_q;
	logic [63:0] res_q;
	logic        sat_q;
	logic        done_q;

	logic [63:0] prod;
	logic [63:0] rl;
	logic        rh_nz;
	logic [63:0] cap;
	logic        ovf;
	logic [63:0] mag_val;

	assign prod = {32'd0, (phase_q == 2'd1) ? ua_q[31:0] : ua_q[63:32]} * {32'd0, ub_q};

	always_comb begin
		if (sel_q == MS_V) begin
			rl    = prod_q[79:16];
			rh_nz = |prod_q[95:80];
		end else begin
			rl    = prod_q[91:28];
			rh_nz = |prod_q[95:92];
		end
		if (sel_q == MS_TERM) begin
			cap = neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		end else begin
			cap = neg_q ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
		end
		ovf     = rh_nz || (rl > cap);
		mag_val = ovf ? cap : rl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == 2'd3);
			if (start) begin
				phase_q <= 2'd1;
			end else if (phase_q != 2'd0) begin
				phase_q <= phase_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= ua;
			ub_q  <= ub;
			neg_q <= neg;
			sel_q <= sel;
		end
		if (phase_q == 2'd1) begin
			prod_q <= {32'd0, prod};
		end else if (phase_q == 2'd2) begin
			prod_q <= prod_q + {prod, 32'd0};
		end
		if (phase_q == 2'd3) begin
			res_q <= neg_q ? (~mag_val + 64'd1) : mag_val;
			sat_q <= ovf;
		end
	end

	assign done = done_q;
	assign res  = res_q;
	assign sat  = sat_q;
endmodule

// File: hw/rtl/mpe_dp.sv
// Datapath: channel tables, sample store, working registers and the multiply unit.
module mpe_dp #(
	parameter int CHANNELS  = mpe_pkg::CHANNELS_DEF,
	parameter int MAX_VARS  = mpe_pkg::MAX_VARS_DEF,
	parameter int MAX_TERMS = mpe_pkg::MAX_TERMS_DEF,
	localparam int VCNT_W   = $clog2(MAX_VARS + 1),
	localparam int TCNT_W   = $clog2(MAX_TERMS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         cmd,
	input  logic [3:0]         channel,
	input  logic [5:0]         slot,
	input  logic [31:0]        value_a,
	input  logic [31:0]        value_b,
	input  logic [31:0]        powers,
	input  logic [3:0]         count_vars,
	input  logic [6:0]         count_terms,
	input  logic               last,
	input  logic               accept,
	input  mpe_pkg::ctl_t      ctl,
	input  logic [VCNT_W-1:0]  var_cnt,
	input  logic [TCNT_W-1:0]  term_cnt,
	output mpe_pkg::sts_t      sts,
	output logic [63:0]        result,
	output logic               saturated
);
	import mpe_pkg::*;

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int VAR_W  = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
	localparam int TERM_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int RNG_AW = CH_W + VAR_W;
	localparam int TRM_AW = CH_W + TERM_W;

	logic [CH_W-1:0]   ch_idx;
	logic              ch_ok;
	logic [VAR_W-1:0]  vi;
	logic [CH_W-1:0]   ch_q;

	logic [31:0]       mean_q   [CHANNELS];
	logic [VCNT_W-1:0] nv_tab_q [CHANNELS];
	logic [TCNT_W-1:0] nt_tab_q [CHANNELS];
	logic [31:0]       sample_q [MAX_VARS];
	logic [31:0]       vv_q     [MAX_VARS];

	logic [VCNT_W-1:0] nv_q;
	logic [TCNT_W-1:0] nt_q;
	logic [63:0]       acc_q;
	logic [63:0]       term_q;
	logic [31:0]       r_q;
	logic [31:0]       pw_q;
	logic              sat_q;
	mul_sel_t          dst_q;
	logic [63:0]       result_q;
	logic              sat_out_q;

	logic              rng_we;
	logic              trm_we;
	logic [63:0]       rng_rdata;
	logic [63:0]       trm_rdata;

	logic [32:0]       diff;
	logic [32:0]       diff_mag;
	logic [31:0]       scale_mag;
	logic [31:0]       r_mag;
	logic [31:0]       v_mag;
	logic [63:0]       term_mag;
	logic [63:0]       m_ua;
	logic [31:0]       m_ub;
	logic              m_neg;
	logic              m_done;
	logic [63:0]       m_res;
	logic              m_sat;

	logic [32:0]       v_sum;
	logic              v_ovf;
	logic [63:0]       add_sum;
	logic              add_ovf;

	assign ch_idx = CH_W'(channel);
	assign ch_ok  = ({5'd0, channel} < 9'(CHANNELS));
	assign vi     = var_cnt[VAR_W-1:0];

	assign rng_we = accept && ch_ok && (cmd == CMD_RANGE) && (slot < 6'(MAX_VARS));
	assign trm_we = accept && ch_ok && (cmd == CMD_TERM) && ({3'd0, slot} < 9'(MAX_TERMS));

	// Range entry: scale in the upper half, max in the lower half.
	mpe_ram #(.WIDTH(64), .DEPTH(1 << RNG_AW)) u_rng_ram (
		.clk   (clk),
		.we    (rng_we),
		.waddr ({ch_idx, VAR_W'(slot)}),
		.wdata ({value_b, value_a}),
		.re    (ctl.rng_rd),
		.raddr ({ch_q, vi}),
		.rdata (rng_rdata)
	);

	// Term entry: powers in the upper half, coefficient in the lower half.
	mpe_ram #(.WIDTH(64), .DEPTH(1 << TRM_AW)) u_trm_ram (
		.clk   (clk),
		.we    (trm_we),
		.waddr ({ch_idx, TERM_W'(slot)}),
		.wdata ({powers, value_a}),
		.re    (ctl.coef_rd),
		.raddr ({ch_q, term_cnt[TERM_W-1:0]}),
		.rdata (trm_rdata)
	);

	always_comb begin
		diff      = {sample_q[vi][31], sample_q[vi]} - {rng_rdata[31], rng_rdata[31:0]};
		diff_mag  = diff[32] ? (~diff + 33'd1) : diff;
		scale_mag = rng_rdata[63] ? (~rng_rdata[63:32] + 32'd1) : rng_rdata[63:32];
		r_mag     = r_q[31] ? (~r_q + 32'd1) : r_q;
		v_mag     = vv_q[vi][31] ? (~vv_q[vi] + 32'd1) : vv_q[vi];
		term_mag  = term_q[63] ? (~term_q + 64'd1) : term_q;
		unique case (ctl.mul_sel)
			MS_V: begin
				m_ua  = {31'd0, diff_mag};
				m_ub  = scale_mag;
				m_neg = diff[32] ^ rng_rdata[63];
			end
			MS_POW: begin
				m_ua  = {32'd0, r_mag};
				m_ub  = v_mag;
				m_neg = r_q[31] ^ vv_q[vi][31];
			end
			MS_TERM: begin
				m_ua  = term_mag;
				m_ub  = r_mag;
				m_neg = term_q[63] ^ r_q[31];
			end
			default: begin
				m_ua  = 64'd0;
				m_ub  = 32'd0;
				m_neg = 1'b0;
			end
		endcase
	end

	mpe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.mul_start),
		.sel    (ctl.mul_sel),
		.ua     (m_ua),
		.ub     (m_ub),
		.neg    (m_neg),
		.done   (m_done),
		.res    (m_res),
		.sat    (m_sat)
	);

	assign v_sum   = {m_res[31], m_res[31:0]} + {1'b0, ONE_Q28};
	assign v_ovf   = (v_sum[32:31] == 2'b01);
	assign add_sum = acc_q + term_q;
	assign add_ovf = (acc_q[63] == term_q[63]) && (add_sum[63] != acc_q[63]);

	// Count tables reset to zero; the value tables are valid only once written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				nv_tab_q[c] <= '0;
				nt_tab_q[c] <= '0;
			end
		end else if (accept && ch_ok && (cmd == CMD_HEADER)) begin
			nv_tab_q[ch_idx] <= ({1'b0, count_vars} > 5'(MAX_VARS)) ?
				VCNT_W'(MAX_VARS) : VCNT_W'(count_vars);
			nt_tab_q[ch_idx] <= ({2'd0, count_terms} > 9'(MAX_TERMS)) ?
				TCNT_W'(MAX_TERMS) : TCNT_W'(count_terms);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && ch_ok && (cmd == CMD_HEADER)) begin
			mean_q[ch_idx] <= value_a;
		end
		if (accept && ch_ok && (cmd == CMD_SAMPLE) && (slot < 6'(MAX_VARS))) begin
			sample_q[VAR_W'(slot)] <= value_a;
		end
		if (ctl.acc_init) begin
			ch_q  <= ch_idx;
			nv_q  <= nv_tab_q[ch_idx];
			nt_q  <= nt_tab_q[ch_idx];
			acc_q <= {{16{mean_q[ch_idx][31]}}, mean_q[ch_idx], 16'd0};
			sat_q <= 1'b0;
		end else begin
			if (ctl.mul_start) begin
				dst_q <= ctl.mul_sel;
			end
			if (m_done) begin
				unique case (dst_q)
					MS_V: begin
						vv_q[vi] <= v_ovf ? 32'h7FFF_FFFF : v_sum[31:0];
						sat_q    <= sat_q | m_sat | v_ovf;
					end
					MS_POW: begin
						r_q   <= m_res[31:0];
						sat_q <= sat_q | m_sat;
					end
					MS_TERM: begin
						term_q <= m_res;
						sat_q  <= sat_q | m_sat;
					end
					default: begin
						sat_q <= sat_q;
					end
				endcase
			end
			if (ctl.r_load) begin
				r_q <= vv_q[vi];
			end
			if (ctl.term_load) begin
				term_q <= {{16{trm_rdata[31]}}, trm_rdata[31:0], 16'd0};
				pw_q   <= trm_rdata[63:32];
			end
			if (ctl.term_zero) begin
				term_q <= 64'd0;
			end
			if (ctl.acc_add) begin
				acc_q <= add_ovf ? (acc_q[63] ? 64'h8000_0000_0000_0000 :
					64'h7FFF_FFFF_FFFF_FFFF) : add_sum;
				sat_q <= sat_q | add_ovf;
			end
		end
		if (ctl.out_load) begin
			result_q  <= acc_q;
			sat_out_q <= sat_q;
		end
	end

	assign sts.eval_req = ch_ok && (cmd == CMD_SAMPLE) && last;
	assign sts.var_end  = (var_cnt == nv_q);
	assign sts.term_end = (term_cnt == nt_q);
	assign sts.mul_done = m_done;
	assign sts.pnib     = pw_q[{vi, 2'b00} +: 4];

	assign result    = result_q;
	assign saturated = sat_out_q;
endmodule

// File: hw/rtl/mpe_ctrl.sv
// Controller: sequences table writes, the variable pass, the term walk and the output.
module mpe_ctrl #(
	parameter int MAX_VARS  = mpe_pkg::MAX_VARS_DEF,
	parameter int MAX_TERMS = mpe_pkg::MAX_TERMS_DEF,
	localparam int VCNT_W   = $clog2(MAX_VARS + 1),
	localparam int TCNT_W   = $clog2(MAX_TERMS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic              accept,
	output mpe_pkg::ctl_t     ctl,
	output logic [VCNT_W-1:0] var_cnt,
	output logic [TCNT_W-1:0] term_cnt,
	input  mpe_pkg::sts_t     sts
);
	import mpe_pkg::*;

	state_t            state_q;
	state_t            state_d;
	logic [VCNT_W-1:0] vi_q;
	logic [TCNT_W-1:0] ti_q;
	logic [3:0]        k_q;
	logic              out_valid_q;

	assign accept = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (accept && sts.eval_req) state_d = S_VRD;
			S_VRD:   state_d = sts.var_end ? S_TRD : S_VMUL;
			S_VMUL:  state_d = S_VWAIT;
			S_VWAIT: if (sts.mul_done) state_d = S_VRD;
			S_TRD:   state_d = sts.term_end ? S_DONE : S_TLOAD;
			S_TLOAD: state_d = S_FAC;
			S_FAC: begin
				if (sts.var_end) begin
					state_d = S_ACC;
				end else if (sts.pnib > 4'd1) begin
					state_d = S_POW;
				end
			end
			S_POW:   state_d = (k_q == 4'd0) ? S_TWAIT : S_PWAIT;
			S_PWAIT: if (sts.mul_done) state_d = S_POW;
			S_TWAIT: if (sts.mul_done) state_d = S_FAC;
			S_ACC:   state_d = S_TRD;
			S_DONE:  if (!out_valid_q || m_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl      = '0;
		ctl.mul_sel = MS_V;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready     = 1'b1;
				ctl.acc_init = s_tvalid && sts.eval_req;
			end
			S_VRD:   ctl.rng_rd = !sts.var_end;
			S_VMUL:  ctl.mul_start = 1'b1;
			S_TRD:   ctl.coef_rd = !sts.term_end;
			S_TLOAD: ctl.term_load = 1'b1;
			S_FAC: begin
				ctl.term_zero = !sts.var_end && (sts.pnib == 4'd0);
				ctl.r_load    = !sts.var_end && (sts.pnib > 4'd1);
			end
			S_POW: begin
				ctl.mul_start = 1'b1;
				ctl.mul_sel   = (k_q == 4'd0) ? MS_TERM : MS_POW;
			end
			S_ACC:   ctl.acc_add = 1'b1;
			S_DONE:  ctl.out_load = !out_valid_q || m_tready;
			default: ctl.mul_sel = MS_V;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vi_q        <= '0;
			ti_q        <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE:  vi_q <= '0;
				S_VWAIT: if (sts.mul_done) vi_q <= vi_q + 1'b1;
				S_VRD:   ti_q <= '0;
				S_TLOAD: vi_q <= '0;
				S_FAC: begin
					if (!sts.var_end) begin
						if (sts.pnib > 4'd1) begin
							k_q <= sts.pnib - 4'd2;
						end else begin
							vi_q <= vi_q + 1'b1;
						end
					end
				end
				S_PWAIT: if (sts.mul_done) k_q <= k_q - 4'd1;
				S_TWAIT: if (sts.mul_done) vi_q <= vi_q + 1'b1;
				S_ACC:   ti_q <= ti_q + 1'b1;
				default: k_q <= k_q;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign var_cnt  = vi_q;
	assign term_cnt = ti_q;
endmodule

// File: hw/rtl/multivariate_polynomial_eval.sv
// Top level of the per-channel multivariate polynomial evaluator.
//
//   Channel   Dir  Fields
//   s_axis    in   tuser: cmd, channel; tlast: last; tdata: slot .. count_terms
//   m_axis    out  tdata: result (Q32.32); tuser: saturated
//
// A table write (header, variable range, term) or a sample with tlast low
// is taken while the block is idle. A sample with tlast high starts an
// evaluation: a variable pass that forms the value of each variable, then
// a term walk that multiplies each term by the powers of its variables and
// adds it to the accumulator. The shared 32x32 multiplier forms each
// product from two partial products, one after the other.
// Reset clears the control state and the variable and term counts of every
// channel; the value tables hold nothing meaningful until written.
// While an evaluation runs s_tready is low. A finished result waits in the
// output register, and the next item is taken while it waits.
module multivariate_polynomial_eval #(
	parameter int CHANNELS  = mpe_pkg::CHANNELS_DEF,
	parameter int MAX_VARS  = mpe_pkg::MAX_VARS_DEF,
	parameter int MAX_TERMS = mpe_pkg::MAX_TERMS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// slot[5:0], value_a[37:6], value_b[69:38], powers[101:70],
	// count_vars[105:102], count_terms[112:106], zero fill above.
	input  logic [119:0] s_tdata,
	// cmd[1:0], channel[5:2].
	input  logic [5:0]   s_tuser,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// result[63:0].
	output logic [63:0]  m_tdata,
	// saturated[0].
	output logic [0:0]   m_tuser
);
	import mpe_pkg::*;

	localparam int VCNT_W = $clog2(MAX_VARS + 1);
	localparam int TCNT_W = $clog2(MAX_TERMS + 1);

	// Control and status between the sequencer and the datapath.
	ctl_t              ctl;
	sts_t              sts;
	logic              accept;
	logic [VCNT_W-1:0] var_cnt;
	logic [TCNT_W-1:0] term_cnt;

	mpe_ctrl #(
		.MAX_VARS  (MAX_VARS),
		.MAX_TERMS (MAX_TERMS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.accept   (accept),
		.ctl      (ctl),
		.var_cnt  (var_cnt),
		.term_cnt (term_cnt),
		.sts      (sts)
	);

	// The datapath writes the tables on each accepted transfer and runs the
	// arithmetic of an evaluation under the sequencer's commands.
	mpe_dp #(
		.CHANNELS  (CHANNELS),
		.MAX_VARS  (MAX_VARS),
		.MAX_TERMS (MAX_TERMS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (s_tuser[1:0]),
		.channel     (s_tuser[5:2]),
		.slot        (s_tdata[5:0]),
		.value_a     (s_tdata[37:6]),
		.value_b     (s_tdata[69:38]),
		.powers      (s_tdata[101:70]),
		.count_vars  (s_tdata[105:102]),
		.count_terms (s_tdata[112:106]),
		.last        (s_tlast),
		.accept      (accept),
		.ctl         (ctl),
		.var_cnt     (var_cnt),
		.term_cnt    (term_cnt),
		.sts         (sts),
		.result      (m_tdata),
		.saturated   (m_tuser[0])
	);
endmodule

// File: hw/rtl/mpe_checker.sv
// Port-level checks of the evaluator, bound to the top level.
module mpe_checker #(
	parameter int CHANNELS = mpe_pkg::CHANNELS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [5:0]   s_tuser,
	input logic         s_tlast,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [63:0]  m_tdata,
	input logic [0:0]   m_tuser
);
	import mpe_pkg::*;

	logic eval_xfer;

	assign eval_xfer = s_tvalid && s_tready && (s_tuser[1:0] == CMD_SAMPLE) && s_tlast &&
		({5'd0, s_tuser[5:2]} < 9'(CHANNELS));

	// A result that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// No result is offered while reset is held.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	// An evaluating transfer makes the block busy in the next cycle.
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		eval_xfer |=> !s_tready)
		else $error("input still ready after evaluation start");

	// A new result only appears at the end of an evaluation.
	a_result_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without an evaluation");
endmodule

bind multivariate_polynomial_eval mpe_checker #(.CHANNELS(CHANNELS)) u_mpe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: sim/mpe_checker.sv
// Checker that predicts and compares the evaluator's results from the observed transfers.
`timescale 1ns / 1ps
module mpe_scoreboard (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [119:0] s_tdata,
	input  logic [5:0]   s_tuser,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [63:0]  m_tdata,
	input  logic [0:0]   m_tuser,
	output int           fail_count,
	output int           pending
);
	import mpe_pkg::*;

	localparam int NCH = CHANNELS_DEF;
	localparam int NV  = MAX_VARS_DEF;
	localparam int NT  = MAX_TERMS_DEF;
	localparam longint I64MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam longint I64MIN = -64'sh7fff_ffff_ffff_ffff - 1;
	localparam longint I32MAX = 64'sh7fff_ffff;

	typedef struct packed {
		logic [63:0] value;
		logic        sat;
	} poly_out_t;

	logic [31:0] max_tab [NCH*NV];
	logic [31:0] scale_tab [NCH*NV];
	logic [31:0] coef_tab [NCH*NT];
	logic [31:0] pow_tab [NCH*NT];
	logic [31:0] mean_tab [NCH];
	logic [3:0]  nvar_tab [NCH];
	logic [6:0]  nterm_tab [NCH];
	logic [31:0] samples [NV];
	poly_out_t   expected_q [$];

	// Truncating product a*b >> sh, saturated to [-lim-1, lim]; the 128-bit
	// signed product is wide enough for every operand pair used here.
	function automatic longint mul_trunc(longint a, longint b, int sh, longint lim,
			inout bit sat);
		logic signed [127:0] p;
		logic [127:0]        m;
		logic                neg;
		p   = $signed(a) * $signed(b);
		neg = p < 0;
		m   = neg ? -p : p;
		m   = m >> sh;
		if (m > (neg ? 128'(lim) + 1 : 128'(lim))) begin
			sat = 1;
			m   = neg ? 128'(lim) + 1 : 128'(lim);
		end
		return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	function automatic longint add_sat(longint a, longint b, inout bit sat);
		if (b > 0 && a > I64MAX - b) begin
			sat = 1;
			return I64MAX;
		end
		if (b < 0 && a < I64MIN - b) begin
			sat = 1;
			return I64MIN;
		end
		return a + b;
	endfunction

	function automatic poly_out_t eval_channel(int ch);
		bit        sat;
		longint    v [NV];
		longint    acc, term, diff, f;
		int        p;
		poly_out_t r;
		sat = 0;
		acc = longint'($signed(mean_tab[ch])) * 65536;
		for (int i = 0; i < nvar_tab[ch]; i++) begin
			diff = longint'($signed(samples[i])) - longint'($signed(max_tab[ch*NV+i]));
			v[i] = 64'sh1000_0000 + mul_trunc(diff, longint'($signed(scale_tab[ch*NV+i])),
				16, I32MAX, sat);
			if (v[i] > I32MAX) begin
				v[i] = I32MAX;
				sat  = 1;
			end
			if (v[i] < -I32MAX - 1) begin
				v[i] = -I32MAX - 1;
				sat  = 1;
			end
		end
		for (int t = 0; t < nterm_tab[ch]; t++) begin
			term = longint'($signed(coef_tab[ch*NT+t])) * 65536;
			for (int i = 0; i < nvar_tab[ch]; i++) begin
				p = pow_tab[ch*NT+t][4*i +: 4];
				if (p == 0)
					f = 0;
				else if (p == 1)
					f = 64'sh1000_0000;
				else begin
					f = v[i];
					for (int k = 2; k < p; k++)
						f = mul_trunc(f, v[i], 28, I32MAX, sat);
				end
				term = mul_trunc(term, f, 28, I64MAX, sat);
			end
			acc = add_sat(acc, term, sat);
		end
		r.value = acc;
		r.sat   = sat;
		return r;
	endfunction

	int mismatches;
	assign fail_count = mismatches;
	assign pending    = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic [1:0]  cmd;
		logic [3:0]  ch;
		logic [5:0]  slot;
		logic [31:0] va;
		poly_out_t   exp_r;
		if (!arst_n) begin
			mismatches <= 0;
			for (int c = 0; c < NCH; c++) begin
				nvar_tab[c]  = '0;
				nterm_tab[c] = '0;
			end
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("unexpected result %h sat %b", m_tdata, m_tuser);
				end else begin
					exp_r = expected_q.pop_front();
					if (exp_r.value !== m_tdata || exp_r.sat !== m_tuser[0]) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("mismatch: expected %h sat %b, got %h sat %b",
								exp_r.value, exp_r.sat, m_tdata, m_tuser);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				cmd  = s_tuser[1:0];
				ch   = s_tuser[5:2];
				slot = s_tdata[5:0];
				va   = s_tdata[37:6];
				case (cmd)
					CMD_HEADER: begin
						mean_tab[ch]  = va;
						nvar_tab[ch]  = s_tdata[105:102] > NV ? 4'(NV) : s_tdata[105:102];
						nterm_tab[ch] = s_tdata[112:106] > NT ? 7'(NT) : s_tdata[112:106];
					end
					CMD_RANGE: if (slot < NV) begin
						max_tab[ch*NV+slot]   = va;
						scale_tab[ch*NV+slot] = s_tdata[69:38];
					end
					CMD_TERM: if (slot < NT) begin
						coef_tab[ch*NT+slot] = va;
						pow_tab[ch*NT+slot]  = s_tdata[101:70];
					end
					default: begin
						if (slot < NV)
							samples[slot] = va;
						if (s_tlast)
							expected_q.push_back(eval_channel(ch));
					end
				endcase
			end
		end
	end
endmodule

// File: sim/tb.sv
// Testbench top: drives table loads and samples into the evaluator and gives the verdict.
`timescale 1ns / 1ps
module tb;
	import mpe_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [119:0] s_tdata;
	logic [5:0]   s_tuser;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic [0:0]   m_tuser;
	int           fail_count;
	int           pending;

	// Idle percentages of sender and receiver for the current phase.
	int  send_idle_pct;
	int  recv_stall_pct;
	// While set, the receiver holds m_tready low to back the block up.
	bit  hold_off;

	multivariate_polynomial_eval u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	mpe_scoreboard u_checker (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// The run limit assumes worst-case evaluations of about 64 terms with
	// high powers under heavy stall, with a wide margin on top.
	initial begin
		#400ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// Receiver: random stalls at the falling edge, plus the long hold-off.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	// Sends one item, with random idle cycles first, and waits for its transfer.
	// The item stays offered afterwards until the next send or stop.
	task automatic send(logic [1:0] cmd, logic [3:0] ch, int unsigned slot, logic [31:0] va,
			logic [31:0] vb, logic [31:0] pw, int unsigned nv, int unsigned nt,
			int unsigned lst);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= {ch, cmd};
		s_tlast  <= lst[0];
		s_tdata  <= {7'b0, 7'(nt), 4'(nv), pw, vb, va, 6'(slot)};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Withdraws the offer once a sequence of sends is over.
	task automatic stop();
		s_tvalid <= 1'b0;
	endtask

	// Random Q4.28 scale, mostly modest so that v stays meaningful, sometimes wild.
	function automatic logic [31:0] rand_scale();
		if ($urandom_range(9) == 0)
			return $urandom;
		return $urandom_range(32'h0400_0000) - 32'h0200_0000;
	endfunction

	function automatic logic [31:0] rand_q16();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'h7fff_ffff;
			2: return 32'h8000_0000;
			default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
		endcase
	endfunction

	// Loads one channel: header, every variable range and every term.
	task automatic load_channel(logic [3:0] ch, logic [3:0] nv, logic [6:0] nt, bit wild);
		logic [31:0] pw;
		send(CMD_HEADER, ch, $urandom, rand_q16(), $urandom, $urandom, nv, nt, $urandom);
		for (int i = 0; i < 8; i++)
			send(CMD_RANGE, ch, i, rand_q16(), rand_scale(), $urandom, $urandom,
				$urandom, $urandom);
		for (int t = 0; t < (nt > 64 ? 64 : nt); t++) begin
			pw = $urandom;
			// Keep most powers small so evaluations stay short.
			if (!wild)
				for (int i = 0; i < 8; i++)
					pw[4*i +: 4] = 4'($urandom_range(3));
			send(CMD_TERM, ch, t, rand_q16(), $urandom, pw, $urandom, $urandom, $urandom);
		end
	endtask

	// Fills every sample variable, the last one triggering the evaluation.
	task automatic sample_run(logic [3:0] ch);
		for (int i = 0; i < 8; i++)
			send(CMD_SAMPLE, ch, i, rand_q16(), $urandom, $urandom, $urandom, $urandom,
				(i == 7) ? 1 : 0);
	endtask

	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	initial begin
		logic [3:0] ch;
		hold_off       = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		s_tlast  = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: a header with zero counts gives the mean alone.
		send(CMD_HEADER, 4'd3, 0, 32'h0001_8000, '0, '0, 0, 0, 0);
		send(CMD_SAMPLE, 4'd3, 0, 32'h0001_0000, '0, '0, '0, '0, 1);
		// Extreme fields, oversized counts clamp, out-of-range slots ignored.
		load_channel(4'd0, 4'd15, 7'd127, 1'b1);
		load_channel(4'd15, 4'd8, 7'd3, 1'b1);
		load_channel(4'd1, 4'd0, 7'd0, 1'b0);
		sample_run(4'd0);
		send(CMD_RANGE, 4'd0, 63, 32'hffff_ffff, 32'hffff_ffff, '1, '1, '1, 1);
		send(CMD_TERM, 4'd0, 63, 32'h7fff_ffff, '1, 32'hffff_ffff, '1, '1, 1);
		send(CMD_SAMPLE, 4'd0, 63, 32'h8000_0000, '1, '1, '1, '1, 1);
		sample_run(4'd15);
		send(CMD_SAMPLE, 4'd1, 5, '0, '0, '0, '0, '0, 1);
		for (int c = 2; c < 15; c++)
			load_channel(4'(c), 4'($urandom_range(8)), 7'($urandom_range(6)), 1'b0);
		stop();
		drain();

		// Long receiver hold-off while items keep coming, to fill the block.
		hold_off = 1;
		fork
			begin
				repeat (3) sample_run(4'd2);
				stop();
			end
			begin
				repeat (3000) @(posedge clk);
				hold_off = 0;
			end
		join
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 65 : 31) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 65 : 31) : 0;
			repeat (36) begin
				ch = 4'($urandom);
				case ($urandom_range(9))
					0: load_channel(ch, 4'($urandom_range(8)), 7'($urandom_range(8)), 1'b0);
					1: send(CMD_SAMPLE, ch, $urandom_range(7), rand_q16(), $urandom,
						$urandom, $urandom, $urandom, 1);
					// Range and term rewrites only, so no count ever covers unwritten terms.
					2: send(2'($urandom_range(2, 1)), ch, $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom, $urandom);
					default: sample_run(ch);
				endcase
			end
		end
		stop();
		drain();

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// File: multivariate_polynomial_eval.f
hw/rtl/mpe_pkg.sv
hw/rtl/mpe_ram.sv
hw/rtl/mpe_mul.sv
hw/rtl/mpe_dp.sv
hw/rtl/mpe_ctrl.sv
hw/rtl/multivariate_polynomial_eval.sv
hw/rtl/mpe_checker.sv
sim/mpe_checker.sv
sim/tb.sv
